@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define SRVM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("srvm assertion failed");

// Same-cycle implication built on the macro above.
`define SRVM_ASSERT_IMP(lbl, clk, rstn, cond, expr) \
  `SRVM_ASSERT(lbl, clk, rstn, (cond) |-> (expr))

`endif

@@ sv/srvm_pkg.sv @@
// Types, codes and decode helpers of the stack and register VM execute block.
`timescale 1ns / 1ps

package srvm_pkg;

  // Operation codes.
  localparam logic [5:0] OP_IN        = 6'd0;
  localparam logic [5:0] OP_OUT       = 6'd1;
  localparam logic [5:0] OP_PUSH      = 6'd2;
  localparam logic [5:0] OP_POP       = 6'd3;
  localparam logic [5:0] OP_PUSHR     = 6'd4;
  localparam logic [5:0] OP_POPR      = 6'd5;
  localparam logic [5:0] OP_MOV       = 6'd6;
  localparam logic [5:0] OP_SQRT      = 6'd7;
  localparam logic [5:0] OP_CMP       = 6'd8;
  localparam logic [5:0] OP_JMP       = 6'd9;
  localparam logic [5:0] OP_JL        = 6'd10;
  localparam logic [5:0] OP_JLE       = 6'd11;
  localparam logic [5:0] OP_JEQ       = 6'd12;
  localparam logic [5:0] OP_JGE       = 6'd13;
  localparam logic [5:0] OP_JG        = 6'd14;
  localparam logic [5:0] OP_CALL      = 6'd15;
  localparam logic [5:0] OP_RET       = 6'd16;
  localparam logic [5:0] OP_ADD       = 6'd17;
  localparam logic [5:0] OP_SUB       = 6'd18;
  localparam logic [5:0] OP_MUL       = 6'd19;
  localparam logic [5:0] OP_MOD       = 6'd20;
  localparam logic [5:0] OP_DIV       = 6'd21;
  localparam logic [5:0] OP_REG_FIRST = 6'd22;
  localparam logic [5:0] OP_REG_LAST  = 6'd51;
  localparam logic [5:0] FORMS_PER_OP = 6'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd1;
  localparam logic [2:0] ERR_STK_UNDER = 3'd2;
  localparam logic [2:0] ERR_STK_OVER  = 3'd3;
  localparam logic [2:0] ERR_RET_UNDER = 3'd4;
  localparam logic [2:0] ERR_RET_OVER  = 3'd5;
  localparam logic [2:0] ERR_BAD_ADDR  = 3'd6;
  localparam logic [2:0] ERR_NEG_SQRT  = 3'd7;

  // Compare flag codes.
  localparam logic [1:0] FLAG_EQ = 2'd0;
  localparam logic [1:0] FLAG_GT = 2'd1;
  localparam logic [1:0] FLAG_LT = 2'd2;

  localparam int unsigned CODE_FIELD_BITS = 16;
  localparam logic [15:0] CALL_RETURN_OFFSET = 16'd9;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_MOD, ALU_MOV, ALU_DIV
  } alu_e;

  typedef enum logic [2:0] {
    FORM_RL, FORM_RR, FORM_SR, FORM_RS, FORM_SS
  } form_e;

  typedef enum logic [1:0] {
    MDU_MUL, MDU_DIV, MDU_MOD, MDU_SQRT
  } mdu_op_e;

  typedef struct packed {
    alu_e  k;
    form_e f;
  } reg_form_t;

  typedef struct packed {
    logic [5:0]  operation;
    logic [3:0]  reg_left;
    logic [3:0]  reg_right;
    logic [63:0] immediate;
    logic [15:0] target_address;
    logic [15:0] current_pc;
    logic [63:0] in_value;
  } req_t;

  typedef struct packed {
    logic        redirect;
    logic [15:0] redirect_address;
    logic        out_valid;
    logic [63:0] out_value;
    logic [2:0]  error_code;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic rd_ops;
    logic rd_dst;
    logic rd_src;
    logic start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_unit;
    logic unit_busy;
    logic out_free;
  } ctrl_sts_t;

  // Split a register-form code into ALU kind and operand form.
  function automatic reg_form_t reg_form(input logic [5:0] op);
    logic [5:0] f;
    logic [2:0] k;
    reg_form_t  r;
    f = op - OP_REG_FIRST;
    k = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (f >= FORMS_PER_OP) begin
        f = f - FORMS_PER_OP;
        k = k + 3'd1;
      end
    end
    r.k = alu_e'(k);
    r.f = form_e'(f[2:0]);
    return r;
  endfunction

  // ALU kind of the stack arithmetic codes.
  function automatic alu_e stack_alu(input logic [5:0] op);
    alu_e k;
    unique case (op)
      OP_ADD:  k = ALU_ADD;
      OP_SUB:  k = ALU_SUB;
      OP_MUL:  k = ALU_MUL;
      OP_MOD:  k = ALU_MOD;
      default: k = ALU_DIV;
    endcase
    return k;
  endfunction

endpackage

@@ sv/srvm_if.sv @@
// Request and response channel interfaces of the VM execute block.
`timescale 1ns / 1ps

interface srvm_req_if;
  logic            valid;
  logic            ready;
  srvm_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srvm_rsp_if;
  logic            valid;
  logic            ready;
  srvm_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/srvm_mdu.sv @@
// Iterative multiply, signed divide/modulo and square root unit.
`timescale 1ns / 1ps

module srvm_mdu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  srvm_pkg::mdu_op_e   op_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output logic                busy_o,
  output logic [63:0]         result_o
);

  logic               busy_q;
  logic [6:0]         cnt_q;
  srvm_pkg::mdu_op_e  op_q;
  logic [63:0]        acc_q, opa_q, opb_q;
  logic [64:0]        rem_q;
  logic               negq_q, negr_q;

  logic [79:0] prod;
  logic [64:0] div_sh;
  logic [34:0] sq_sh, sq_trial;
  logic [63:0] abs_a, abs_b;

  assign prod     = opa_q * opb_q[15:0];
  assign div_sh   = {rem_q[63:0], opa_q[63]};
  assign sq_sh    = {rem_q[32:0], opa_q[63:62]};
  assign sq_trial = {1'b0, acc_q[31:0], 2'b01};
  assign abs_a    = a_i[63] ? (64'd0 - a_i) : a_i;
  assign abs_b    = b_i[63] ? (64'd0 - b_i) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      unique case (op_i)
        srvm_pkg::MDU_MUL:  cnt_q <= 7'd4;
        srvm_pkg::MDU_SQRT: cnt_q <= 7'd32;
        default:            cnt_q <= 7'd64;
      endcase
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      acc_q  <= '0;
      rem_q  <= '0;
      negq_q <= a_i[63] ^ b_i[63];
      negr_q <= a_i[63];
      unique case (op_i)
        srvm_pkg::MDU_MUL, srvm_pkg::MDU_SQRT: begin
          opa_q <= a_i;
          opb_q <= b_i;
        end
        default: begin
          opa_q <= abs_a;
          opb_q <= abs_b;
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        srvm_pkg::MDU_MUL: begin
          acc_q <= acc_q + prod[63:0];
          opa_q <= {opa_q[47:0], 16'd0};
          opb_q <= {16'd0, opb_q[63:16]};
        end
        srvm_pkg::MDU_SQRT: begin
          opa_q <= {opa_q[61:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            rem_q <= {30'd0, sq_sh - sq_trial};
            acc_q <= {32'd0, acc_q[30:0], 1'b1};
          end else begin
            rem_q <= {30'd0, sq_sh};
            acc_q <= {32'd0, acc_q[30:0], 1'b0};
          end
        end
        default: begin
          if (div_sh >= {1'b0, opb_q}) begin
            rem_q <= div_sh - {1'b0, opb_q};
            opa_q <= {opa_q[62:0], 1'b1};
          end else begin
            rem_q <= div_sh;
            opa_q <= {opa_q[62:0], 1'b0};
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_q)
      srvm_pkg::MDU_MUL:  result_o = acc_q;
      srvm_pkg::MDU_SQRT: result_o = {32'd0, acc_q[31:0]};
      srvm_pkg::MDU_MOD:  result_o = negr_q ? (64'd0 - rem_q[63:0]) : rem_q[63:0];
      default:            result_o = negq_q ? (64'd0 - opa_q) : opa_q;
    endcase
  end

  assign busy_o = busy_q;

endmodule

@@ sv/srvm_datapath.sv @@
// Datapath: stacks, register file, data memory, operand registers and result register.
`timescale 1ns / 1ps

module srvm_datapath #(
  parameter int unsigned STACK_DEPTH    = 256,
  parameter int unsigned RETURN_DEPTH   = 64,
  parameter int unsigned NUM_REGS       = 16,
  parameter int unsigned DATA_WORDS     = 1024,
  parameter int unsigned CODE_ADDR_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srvm_pkg::ctrl_cmd_t   cmd_i,
  output srvm_pkg::ctrl_sts_t   sts_o,
  input  srvm_pkg::req_t        req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output srvm_pkg::rsp_t        rsp_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned RPW = $clog2(RETURN_DEPTH + 1);
  localparam int unsigned RIW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
  localparam int unsigned RGW = $clog2(NUM_REGS);
  localparam int unsigned DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam logic [15:0] CODE_MASK = (CODE_ADDR_BITS >= srvm_pkg::CODE_FIELD_BITS) ?
                                      16'hFFFF : 16'((32'd1 << CODE_ADDR_BITS) - 32'd1);

  // Fold a register index into the register file range.
  function automatic logic [RGW-1:0] reg_idx(input logic [3:0] v);
    logic [8:0] t;
    t = 9'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= 9'(NUM_REGS)) begin
        t = t - 9'(NUM_REGS);
      end
    end
    return RGW'(t);
  endfunction

  // Storage
  logic [63:0] stk_mem [STACK_DEPTH];
  logic [15:0] ret_mem [RETURN_DEPTH];
  logic [63:0] reg_mem [NUM_REGS];
  logic [63:0] dm_mem  [DATA_WORDS];
  logic [NUM_REGS-1:0] reg_vld_q;

  logic [SPW-1:0] sp_q, sp_d, sp_m1, sp_m2;
  logic [RPW-1:0] rp_q, rp_d, rp_m1;
  logic [1:0]     flag_q, flag_d;

  srvm_pkg::req_t req_q;
  logic [63:0]    rl_q, rr_q, top_q, nxt_q, dm_q, dv_q;
  logic [15:0]    ret_q;
  srvm_pkg::rsp_t rsp_q, rsp_n;
  logic           rsp_vld_q;

  // Decode
  logic [5:0]          op;
  logic [RGW-1:0]      li, ri;
  srvm_pkg::reg_form_t fd;
  srvm_pkg::alu_e      alu_k;
  srvm_pkg::mdu_op_e   mdu_op;
  logic                is_stk_alu, is_reg, dmem, smem, div_zero, take;
  logic [63:0]         alu_a, alu_b, alu_res, mdu_res;
  logic [15:0]         tgt;
  logic [DAW-1:0]      dm_raddr;
  logic                mdu_busy;

  // Write ports
  logic           stk_we, reg_we, ret_we, dm_we;
  logic [SIW-1:0] stk_waddr;
  logic [RGW-1:0] reg_waddr;
  logic [63:0]    stk_wdata, reg_wdata, dm_wdata;
  logic [15:0]    ret_wdata;

  assign op    = req_q.operation;
  assign li    = reg_idx(req_q.reg_left);
  assign ri    = reg_idx(req_q.reg_right);
  assign fd    = srvm_pkg::reg_form(op);
  assign sp_m1 = sp_q - SPW'(1);
  assign sp_m2 = sp_q - SPW'(2);
  assign rp_m1 = rp_q - RPW'(1);
  assign tgt   = req_q.target_address & CODE_MASK;

  assign is_stk_alu = (op >= srvm_pkg::OP_ADD) && (op <= srvm_pkg::OP_DIV);
  assign is_reg     = (op >= srvm_pkg::OP_REG_FIRST) && (op <= srvm_pkg::OP_REG_LAST);
  assign alu_k      = is_stk_alu ? srvm_pkg::stack_alu(op) : fd.k;
  assign dmem       = is_reg && ((fd.f == srvm_pkg::FORM_SR) || (fd.f == srvm_pkg::FORM_SS));
  assign smem       = is_reg && ((fd.f == srvm_pkg::FORM_RS) || (fd.f == srvm_pkg::FORM_SS));
  assign alu_a      = is_stk_alu ? top_q : (dmem ? dv_q : rl_q);
  assign alu_b      = is_stk_alu ? nxt_q :
                      (fd.f == srvm_pkg::FORM_RL) ? req_q.immediate :
                      smem ? dm_q : rr_q;
  assign div_zero   = ((alu_k == srvm_pkg::ALU_MOD) || (alu_k == srvm_pkg::ALU_DIV)) &&
                      (alu_b == 64'd0);

  always_comb begin
    if (op == srvm_pkg::OP_SQRT) begin
      mdu_op = srvm_pkg::MDU_SQRT;
    end else if (alu_k == srvm_pkg::ALU_MUL) begin
      mdu_op = srvm_pkg::MDU_MUL;
    end else if (alu_k == srvm_pkg::ALU_MOD) begin
      mdu_op = srvm_pkg::MDU_MOD;
    end else begin
      mdu_op = srvm_pkg::MDU_DIV;
    end
  end

  srvm_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .op_i     (mdu_op),
    .a_i      ((op == srvm_pkg::OP_SQRT) ? rl_q : alu_a),
    .b_i      (alu_b),
    .busy_o   (mdu_busy),
    .result_o (mdu_res)
  );

  always_comb begin
    case (alu_k)
      srvm_pkg::ALU_ADD: alu_res = alu_a + alu_b;
      srvm_pkg::ALU_SUB: alu_res = alu_a - alu_b;
      srvm_pkg::ALU_MOV: alu_res = alu_b;
      default:           alu_res = mdu_res;
    endcase
  end

  always_comb begin
    case (op)
      srvm_pkg::OP_JMP: take = 1'b1;
      srvm_pkg::OP_JL:  take = (flag_q == srvm_pkg::FLAG_GT);
      srvm_pkg::OP_JLE: take = (flag_q == srvm_pkg::FLAG_GT) || (flag_q == srvm_pkg::FLAG_EQ);
      srvm_pkg::OP_JEQ: take = (flag_q == srvm_pkg::FLAG_EQ);
      srvm_pkg::OP_JGE: take = (flag_q == srvm_pkg::FLAG_LT) || (flag_q == srvm_pkg::FLAG_EQ);
      default:          take = (flag_q == srvm_pkg::FLAG_LT);
    endcase
  end

  // Execute and write back
  always_comb begin
    rsp_n     = '0;
    sp_d      = sp_q;
    rp_d      = rp_q;
    flag_d    = flag_q;
    stk_we    = 1'b0;
    stk_waddr = sp_q[SIW-1:0];
    stk_wdata = alu_res;
    reg_we    = 1'b0;
    reg_waddr = li;
    reg_wdata = alu_res;
    ret_we    = 1'b0;
    ret_wdata = (req_q.current_pc + srvm_pkg::CALL_RETURN_OFFSET) & CODE_MASK;
    dm_we     = 1'b0;
    dm_wdata  = alu_res;
    unique case (op) inside
      srvm_pkg::OP_IN, srvm_pkg::OP_PUSH, srvm_pkg::OP_PUSHR: begin
        if (sp_q >= SPW'(STACK_DEPTH)) begin
          rsp_n.error_code = srvm_pkg::ERR_STK_OVER;
        end else begin
          stk_we    = 1'b1;
          stk_wdata = (op == srvm_pkg::OP_IN)   ? req_q.in_value :
                      (op == srvm_pkg::OP_PUSH) ? req_q.immediate : rl_q;
          sp_d      = sp_q + SPW'(1);
        end
      end
      srvm_pkg::OP_OUT, srvm_pkg::OP_POP, srvm_pkg::OP_POPR: begin
        if (sp_q == '0) begin
          rsp_n.error_code = srvm_pkg::ERR_STK_UNDER;
        end else begin
          sp_d = sp_m1;
          if (op == srvm_pkg::OP_OUT) begin
            rsp_n.out_valid = 1'b1;
            rsp_n.out_value = top_q;
          end
          reg_we    = (op == srvm_pkg::OP_POPR);
          reg_wdata = top_q;
        end
      end
      srvm_pkg::OP_MOV: begin
        reg_we    = 1'b1;
        reg_wdata = req_q.immediate;
      end
      srvm_pkg::OP_SQRT: begin
        if (rl_q[63]) begin
          rsp_n.error_code = srvm_pkg::ERR_NEG_SQRT;
        end else begin
          reg_we    = 1'b1;
          reg_wdata = mdu_res;
        end
      end
      srvm_pkg::OP_CMP: begin
        if (sp_q < SPW'(2)) begin
          rsp_n.error_code = srvm_pkg::ERR_STK_UNDER;
        end else if ($signed(top_q) < $signed(nxt_q)) begin
          flag_d = srvm_pkg::FLAG_LT;
        end else if ($signed(top_q) > $signed(nxt_q)) begin
          flag_d = srvm_pkg::FLAG_GT;
        end else begin
          flag_d = srvm_pkg::FLAG_EQ;
        end
      end
      [srvm_pkg::OP_JMP:srvm_pkg::OP_JG]: begin
        rsp_n.redirect         = take;
        rsp_n.redirect_address = take ? tgt : 16'd0;
      end
      srvm_pkg::OP_CALL: begin
        if (rp_q >= RPW'(RETURN_DEPTH)) begin
          rsp_n.error_code = srvm_pkg::ERR_RET_OVER;
        end else begin
          ret_we                 = 1'b1;
          rp_d                   = rp_q + RPW'(1);
          rsp_n.redirect         = 1'b1;
          rsp_n.redirect_address = tgt;
        end
      end
      srvm_pkg::OP_RET: begin
        if (rp_q == '0) begin
          rsp_n.error_code = srvm_pkg::ERR_RET_UNDER;
        end else begin
          rp_d                   = rp_m1;
          rsp_n.redirect         = 1'b1;
          rsp_n.redirect_address = ret_q;
        end
      end
      [srvm_pkg::OP_ADD:srvm_pkg::OP_DIV]: begin
        if (sp_q < SPW'(2)) begin
          rsp_n.error_code = srvm_pkg::ERR_STK_UNDER;
        end else if (div_zero) begin
          rsp_n.error_code = srvm_pkg::ERR_DIV_ZERO;
        end else begin
          sp_d      = sp_m1;
          stk_we    = 1'b1;
          stk_waddr = sp_m2[SIW-1:0];
        end
      end
      [srvm_pkg::OP_REG_FIRST:srvm_pkg::OP_REG_LAST]: begin
        if ((dmem && (rl_q >= 64'(DATA_WORDS))) || (smem && (rr_q >= 64'(DATA_WORDS)))) begin
          rsp_n.error_code = srvm_pkg::ERR_BAD_ADDR;
        end else if (div_zero) begin
          rsp_n.error_code = srvm_pkg::ERR_DIV_ZERO;
        end else begin
          dm_we  = dmem;
          reg_we = !dmem;
        end
      end
      default: ;
    endcase
  end

  // Request capture and operand reads
  assign dm_raddr = cmd_i.rd_src ? rr_q[DAW-1:0] : rl_q[DAW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.rd_ops) begin
      rl_q  <= reg_vld_q[li] ? reg_mem[li] : 64'd0;
      rr_q  <= reg_vld_q[ri] ? reg_mem[ri] : 64'd0;
      top_q <= stk_mem[sp_m1[SIW-1:0]];
      nxt_q <= stk_mem[sp_m2[SIW-1:0]];
      ret_q <= ret_mem[rp_m1[RIW-1:0]];
    end
    if (cmd_i.rd_dst || cmd_i.rd_src) begin
      dm_q <= dm_mem[dm_raddr];
    end
    if (cmd_i.rd_src) begin
      dv_q <= dm_q;
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ret_we) begin
      ret_mem[rp_q[RIW-1:0]] <= ret_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && reg_we) begin
      reg_mem[reg_waddr] <= reg_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && dm_we) begin
      dm_mem[rl_q[DAW-1:0]] <= dm_wdata;
    end
  end

  // Architectural control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      rp_q      <= '0;
      flag_q    <= srvm_pkg::FLAG_EQ;
      reg_vld_q <= '0;
    end else if (cmd_i.commit) begin
      sp_q   <= sp_d;
      rp_q   <= rp_d;
      flag_q <= flag_d;
      if (reg_we) begin
        reg_vld_q[reg_waddr] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_n;
    end
  end

  assign rsp_valid_o     = rsp_vld_q;
  assign rsp_o           = rsp_q;
  assign sts_o.need_unit = (op == srvm_pkg::OP_SQRT) ||
                           ((is_stk_alu || is_reg) &&
                            ((alu_k == srvm_pkg::ALU_MUL) || (alu_k == srvm_pkg::ALU_MOD) ||
                             (alu_k == srvm_pkg::ALU_DIV)));
  assign sts_o.unit_busy = mdu_busy;
  assign sts_o.out_free  = !rsp_vld_q || rsp_ready_i;

endmodule

@@ sv/srvm_ctrl.sv @@
// Controller: sequences operand reads, the iterative unit and write back.
`timescale 1ns / 1ps

module srvm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  srvm_pkg::ctrl_sts_t  sts_i,
  output srvm_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DST, S_SRC, S_EXEC, S_BUSY, S_WB
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   accept;

  assign accept = req_valid_i && ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = accept;
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_ops = 1'b1;
        state_d      = S_DST;
      end
      S_DST: begin
        cmd_o.rd_dst = 1'b1;
        state_d      = S_SRC;
      end
      S_SRC: begin
        cmd_o.rd_src = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.start = sts_i.need_unit;
        state_d     = sts_i.need_unit ? S_BUSY : S_WB;
      end
      S_BUSY: begin
        if (!sts_i.unit_busy) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.commit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign req_ready_o = ready_q;

endmodule

@@ sv/stack_register_vm_execute.sv @@
// Top level of the stack and register VM execute block.
// Executes one decoded instruction per request and returns exactly one response
// for it. Requests are handled one at a time: each instruction goes through
// accept, register/stack read, two data memory read slots, execute and write
// back before its response is loaded. MUL and the multiply register forms
// also wait on the shared arithmetic unit (four 64x16 partial products), as
// do SQRT and the DIV/MOD forms (one quotient bit per cycle for DIV/MOD).
// The response sits in an output register; write back stalls only while an
// earlier response is still waiting to be taken. There is no clearing pass
// after reset: the register file uses per-entry valid bits, the stack entries
// in use are always ones that were written, and data memory is not cleared.
`timescale 1ns / 1ps

module stack_register_vm_execute #(
  parameter int unsigned STACK_DEPTH    = 256,
  parameter int unsigned RETURN_DEPTH   = 64,
  parameter int unsigned NUM_REGS       = 16,
  parameter int unsigned DATA_WORDS     = 1024,
  parameter int unsigned CODE_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srvm_req_if.sink    req,
  srvm_rsp_if.source  rsp
);

  srvm_pkg::ctrl_cmd_t cmd;
  srvm_pkg::ctrl_sts_t sts;
  srvm_pkg::rsp_t      rsp_payload;
  logic                ready;
  logic                rsp_valid;

  // Sequencer: owns request acceptance and the step order.
  srvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: machine state, operand registers, arithmetic unit and response register.
  srvm_datapath #(
    .STACK_DEPTH    (STACK_DEPTH),
    .RETURN_DEPTH   (RETURN_DEPTH),
    .NUM_REGS       (NUM_REGS),
    .DATA_WORDS     (DATA_WORDS),
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req.payload),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp_payload)
  );

  // Drive the channel ports.
  assign req.ready   = ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_payload;

endmodule

@@ sv/srvm_checker.sv @@
// Port-level checker for the VM execute block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srvm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input srvm_pkg::rsp_t  rsp_i
);

  // A stalled response holds.
  `SRVM_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
  // One request in flight: ready drops right after a request is taken.
  `SRVM_ASSERT(a_one_req, clk_i, rst_ni, req_valid_i && req_ready_i |=> !req_ready_i)
  // A faulting instruction neither redirects nor outputs.
  `SRVM_ASSERT_IMP(a_err_quiet, clk_i, rst_ni, rsp_valid_i && (rsp_i.error_code != srvm_pkg::ERR_NONE), !rsp_i.redirect && !rsp_i.out_valid)
  // Unused response fields read as zero.
  `SRVM_ASSERT_IMP(a_zero_fields, clk_i, rst_ni, rsp_valid_i, (rsp_i.redirect || (rsp_i.redirect_address == 16'd0)) && (rsp_i.out_valid || (rsp_i.out_value == 64'd0)))

endmodule

bind stack_register_vm_execute srvm_checker u_srvm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_i       (rsp.payload)
);
